/* src/stsp_pkg.sv */
package stsp_pkg;

  // Field and register widths.
  localparam int SpeedW   = 26;
  localparam int ClockW   = 24;
  localparam int AccelW   = 28;
  localparam int StepsW   = 24;
  localparam int DistW    = 24;
  localparam int MultW    = 10;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 28;

  // Shared divider: numerator is the widest ramp product, divisor is accel << 9.
  localparam int DivNumW = 53;
  localparam int DivDenW = 37;
  localparam int DivCntW = 6;

  // Iteration counts per division kind.
  localparam logic [DivCntW-1:0] IterRamp  = 6'd53;
  localparam logic [DivCntW-1:0] IterWidth = 6'd32;

  // Register reset values.
  localparam logic [SpeedW-1:0] MinSpeedRst   = 26'd25600;
  localparam logic [ClockW-1:0] StepClockRst  = 24'd170000;
  localparam logic [SpeedW-1:0] MaxSpeedRst   = 26'd2560000;
  localparam logic [AccelW-1:0] MaxAccelRst   = 28'd2560000;
  localparam logic [StepsW-1:0] StepsPerMmRst = 24'd25600;
  // Step clock * 256 / min speed with the reset register values.
  localparam logic [StepsW-1:0] WidthRst      = 24'd1700;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_SPEED    = 3'd0,
    CFG_STEP_CLOCK   = 3'd1,
    CFG_MAX_SPEED    = 3'd2,
    CFG_MAX_ACCEL    = 3'd3,
    CFG_STEPS_PER_MM = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIV_RAMP  = 2'd0,
    DIV_WIDTH = 2'd2
  } div_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_in;
    logic     move_mul;
    logic     move_prod;
    logic     div_start;
    div_sel_e div_sel;
    logic     ramp_load;
    logic     delta_load;
    logic     speed_upd;
    logic     width_load;
    logic     out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ramp_zero;
    logic div_done;
    logic speed_change;
  } dp_stat_t;

endpackage

/* src/stepper_trapezoid_speed_profile.sv */
// Channel   Handshake                 Payload
// -------   ------------------------  -------------------------------------------------
// in        in_valid_i / in_ready_o   mode, remaining_steps, distance_mm, speed_mult
// out       out_valid_o / out_ready_i step_width, speed_now, direction, ramp_steps,
//                                     steps_needed, restart
// cfg       cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// A tick transaction runs a width division only when the speed changes; a move always runs
// one, after a ramp division unless the ramp is zero. All divisions go through the one
// shared divider, which retires one quotient bit a cycle.
// Reset is asynchronous and active low; it loads the default registers and profile.
// One transaction is worked at a time; a new one is taken while a result still waits.
module stepper_trapezoid_speed_profile #(
  parameter int unsigned TICKS_PER_SECOND = 1000
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [stsp_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [stsp_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mode_i,
  input  logic [stsp_pkg::StepsW-1:0]       remaining_steps_i,
  input  logic signed [stsp_pkg::DistW-1:0] distance_mm_i,
  input  logic [stsp_pkg::MultW-1:0]        speed_mult_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [stsp_pkg::StepsW-1:0]       step_width_o,
  output logic [stsp_pkg::SpeedW-1:0]       speed_now_o,
  output logic                              direction_o,
  output logic [stsp_pkg::StepsW-1:0]       ramp_steps_o,
  output logic [stsp_pkg::StepsW-1:0]       steps_needed_o,
  output logic                              restart_o
);
  import stsp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer.
  stsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Registers, arithmetic and divider.
  stsp_datapath #(
    .TicksPerSecond (TICKS_PER_SECOND)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .mode_i            (mode_i),
    .remaining_steps_i (remaining_steps_i),
    .distance_mm_i     (distance_mm_i),
    .speed_mult_i      (speed_mult_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .step_width_o      (step_width_o),
    .speed_now_o       (speed_now_o),
    .direction_o       (direction_o),
    .ramp_steps_o      (ramp_steps_o),
    .steps_needed_o    (steps_needed_o),
    .restart_o         (restart_o)
  );

endmodule

/* src/stsp_div.sv */
module stsp_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [stsp_pkg::DivNumW-1:0]   num_i,
  input  logic [stsp_pkg::DivDenW-1:0]   den_i,
  input  logic [stsp_pkg::DivCntW-1:0]   iters_i,
  output logic                           done_o,
  output logic [stsp_pkg::DivNumW-1:0]   quot_o
);
  import stsp_pkg::*;

  logic [DivNumW-1:0] n_q, n_d;
  logic [DivDenW-1:0] d_q, d_d;
  logic [DivDenW-1:0] r_q, r_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivDenW:0]   shifted;
  logic [DivDenW:0]   diff;

  // One restoring step per cycle; the numerator is left aligned, so the
  // quotient bits fill the register from the bottom as it shifts.
  always_comb begin
    shifted = {r_q, n_q[DivNumW-1]};
    diff    = shifted - {1'b0, d_q};
    n_d     = n_q;
    d_d     = d_q;
    r_d     = r_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      n_d    = num_i;
      d_d    = den_i;
      r_d    = '0;
      cnt_d  = iters_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[DivDenW]) begin
        r_d = diff[DivDenW-1:0];
        n_d = {n_q[DivNumW-2:0], 1'b1};
      end else begin
        r_d = shifted[DivDenW-1:0];
        n_d = {n_q[DivNumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand registers.
  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    d_q <= d_d;
    r_q <= r_d;
  end

  assign done_o = done_q;
  assign quot_o = n_q;

endmodule

/* src/stsp_datapath.sv */
module stsp_datapath #(
  parameter int unsigned TicksPerSecond = 1000
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [stsp_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [stsp_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              mode_i,
  input  logic [stsp_pkg::StepsW-1:0]       remaining_steps_i,
  input  logic signed [stsp_pkg::DistW-1:0] distance_mm_i,
  input  logic [stsp_pkg::MultW-1:0]        speed_mult_i,
  input  stsp_pkg::dp_cmd_t                 cmd_i,
  output stsp_pkg::dp_stat_t                stat_o,
  output logic [stsp_pkg::StepsW-1:0]       step_width_o,
  output logic [stsp_pkg::SpeedW-1:0]       speed_now_o,
  output logic                              direction_o,
  output logic [stsp_pkg::StepsW-1:0]       ramp_steps_o,
  output logic [stsp_pkg::StepsW-1:0]       steps_needed_o,
  output logic                              restart_o
);
  import stsp_pkg::*;

  // Reciprocal for the per-tick step: exact floor(accel / ticks) over 28 bits.
  localparam int unsigned DeltaShift = AccelW + $clog2(TicksPerSecond);
  localparam longint unsigned DeltaRecip =
    ((64'd1 << DeltaShift) + 64'(TicksPerSecond) - 64'd1) / 64'(TicksPerSecond);
  localparam logic [AccelW:0] DeltaRecipV = DeltaRecip[AccelW:0];

  // Configuration registers.
  logic [SpeedW-1:0] min_speed_q;
  logic [ClockW-1:0] step_clock_q;
  logic [SpeedW-1:0] max_speed_q;
  logic [AccelW-1:0] max_accel_q;
  logic [StepsW-1:0] steps_per_mm_q;

  // Latched transaction fields.
  logic              mode_q;
  logic [StepsW-1:0] remaining_q;
  logic [DistW-1:0]  dist_q;
  logic [MultW-1:0]  mult_q;

  // Profile state.
  logic [SpeedW-1:0] speed_q, speed_d;
  logic [SpeedW-1:0] target_q, target_d;
  logic [AccelW-1:0] accel_q, accel_d;
  logic [StepsW-1:0] ramp_q, ramp_d;
  logic              dir_q, dir_d;
  logic [StepsW-1:0] steps_q, steps_d;
  logic [StepsW-1:0] width_q, width_d;
  logic [AccelW-1:0] delta_q;
  logic [DivNumW-1:0] prod_q;

  // Arithmetic intermediates.
  logic [SpeedW+MultW-1:0]  tgt_full;
  logic [AccelW+MultW-1:0]  acc_full;
  logic [StepsW-1:0]        mag;
  logic [2*StepsW-1:0]      steps_full;
  logic [SpeedW-1:0]        dv;
  logic [SpeedW:0]          vsum;
  logic                     falling;
  logic                     speed_change;
  logic [SpeedW-1:0]        down_gap;
  logic [SpeedW-1:0]        up_gap;
  logic [SpeedW-1:0]        speed_tick;
  logic                     ramp_zero;
  logic [DivNumW-1:0]       ramp_raw;
  logic [StepsW-1:0]        half_steps;
  logic [2*AccelW:0]        delta_full;

  // Divider operands.
  logic                     div_done;
  logic [DivNumW-1:0]       quot;
  logic [DivNumW-1:0]       div_num;
  logic [DivDenW-1:0]       div_den;
  logic [DivCntW-1:0]       div_iters;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_speed_q    <= MinSpeedRst;
      step_clock_q   <= StepClockRst;
      max_speed_q    <= MaxSpeedRst;
      max_accel_q    <= MaxAccelRst;
      steps_per_mm_q <= StepsPerMmRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_SPEED:    min_speed_q    <= cfg_data_i[SpeedW-1:0];
        CFG_STEP_CLOCK:   step_clock_q   <= cfg_data_i[ClockW-1:0];
        CFG_MAX_SPEED:    max_speed_q    <= cfg_data_i[SpeedW-1:0];
        CFG_MAX_ACCEL:    max_accel_q    <= cfg_data_i[AccelW-1:0];
        CFG_STEPS_PER_MM: steps_per_mm_q <= cfg_data_i[StepsW-1:0];
        default: ;
      endcase
    end
  end

  // Capture the input transaction.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q      <= mode_i;
      remaining_q <= remaining_steps_i;
      dist_q      <= distance_mm_i;
      mult_q      <= speed_mult_i;
    end
  end

  // Move set-up: scaled target and acceleration, direction, step count and ramp terms.
  always_comb begin
    tgt_full   = mult_q * max_speed_q;
    acc_full   = mult_q * max_accel_q;
    mag        = dist_q[DistW-1] ? (~dist_q + StepsW'(1)) : dist_q;
    steps_full = steps_per_mm_q * mag;
    dv         = target_q - min_speed_q;
    vsum       = {1'b0, min_speed_q} + {1'b0, target_q};
    ramp_zero  = (accel_q == '0) || (target_q <= min_speed_q);
  end

  // Tick update: climb toward the target or fall toward the minimum.
  always_comb begin
    falling  = remaining_q < ramp_q;
    down_gap = speed_q - min_speed_q;
    up_gap   = target_q - speed_q;
    if (falling) begin
      speed_change = speed_q > min_speed_q;
      speed_tick   = ({2'b00, down_gap} <= delta_q) ? min_speed_q
                                                    : speed_q - delta_q[SpeedW-1:0];
    end else begin
      speed_change = speed_q < target_q;
      speed_tick   = ({2'b00, up_gap} <= delta_q) ? target_q
                                                  : speed_q + delta_q[SpeedW-1:0];
    end
  end

  // Ramp length from the quotient, capped at half the move.
  always_comb begin
    half_steps = steps_q >> 1;
    ramp_raw   = ramp_zero ? '0 : quot;
  end

  // Per-tick speed step by reciprocal multiplication.
  always_comb begin
    delta_full = accel_q * DeltaRecipV;
  end

  // Next values of the profile state.
  always_comb begin
    target_d = target_q;
    accel_d  = accel_q;
    dir_d    = dir_q;
    steps_d  = steps_q;
    ramp_d   = ramp_q;
    speed_d  = speed_q;
    width_d  = width_q;
    if (cmd_i.move_mul) begin
      target_d = (|tgt_full[SpeedW+MultW-1:SpeedW+8]) ? '1 : tgt_full[SpeedW+7:8];
      accel_d  = (|acc_full[AccelW+MultW-1:AccelW+8]) ? '1 : acc_full[AccelW+7:8];
      dir_d    = !dist_q[DistW-1];
    end
    if (cmd_i.move_prod) begin
      steps_d = (|steps_full[2*StepsW-1:StepsW+16]) ? '1 : steps_full[StepsW+15:16];
    end
    if (cmd_i.ramp_load) begin
      ramp_d  = (ramp_raw > DivNumW'(half_steps)) ? half_steps : ramp_raw[StepsW-1:0];
      speed_d = min_speed_q;
    end
    if (cmd_i.speed_upd) begin
      speed_d = speed_tick;
    end
    if (cmd_i.width_load) begin
      width_d = (|quot[DivNumW-1:StepsW]) ? '1 : quot[StepsW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q  <= MinSpeedRst;
      target_q <= MinSpeedRst;
      accel_q  <= '0;
      ramp_q   <= '0;
      dir_q    <= 1'b1;
      steps_q  <= '0;
      width_q  <= WidthRst;
    end else begin
      speed_q  <= speed_d;
      target_q <= target_d;
      accel_q  <= accel_d;
      ramp_q   <= ramp_d;
      dir_q    <= dir_d;
      steps_q  <= steps_d;
      width_q  <= width_d;
    end
  end

  // Ramp numerator and per-tick speed step.
  always_ff @(posedge clk_i) begin
    if (cmd_i.move_prod) begin
      prod_q <= dv * vsum;
    end
    if (cmd_i.delta_load) begin
      delta_q <= AccelW'(delta_full >> DeltaShift);
    end
  end

  // Divider operand selection, numerators left aligned.
  always_comb begin
    case (cmd_i.div_sel)
      DIV_RAMP: begin
        div_num   = prod_q;
        div_den   = {accel_q, 9'd0};
        div_iters = IterRamp;
      end
      default: begin
        div_num   = {step_clock_q, 8'd0, (DivNumW-ClockW-8)'(0)};
        div_den   = DivDenW'(speed_q);
        div_iters = IterWidth;
      end
    endcase
  end

  stsp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .iters_i (div_iters),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Result register, free for the next transaction once loaded.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      step_width_o   <= width_q;
      speed_now_o    <= speed_q;
      direction_o    <= dir_q;
      ramp_steps_o   <= ramp_q;
      steps_needed_o <= steps_q;
      restart_o      <= mode_q;
    end
  end

  assign stat_o.ramp_zero    = ramp_zero;
  assign stat_o.div_done     = div_done;
  assign stat_o.speed_change = speed_change;

endmodule

/* src/stsp_ctrl.sv */
module stsp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  stsp_pkg::dp_stat_t stat_i,
  output stsp_pkg::dp_cmd_t  cmd_o
);
  import stsp_pkg::*;

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_MULT       = 4'd1;
  localparam logic [3:0] S_PROD       = 4'd2;
  localparam logic [3:0] S_RAMP_GO    = 4'd3;
  localparam logic [3:0] S_RAMP_WAIT  = 4'd4;
  localparam logic [3:0] S_DELTA_GO   = 4'd5;
  localparam logic [3:0] S_SPEED      = 4'd7;
  localparam logic [3:0] S_WIDTH_GO   = 4'd8;
  localparam logic [3:0] S_WIDTH_WAIT = 4'd9;
  localparam logic [3:0] S_DONE       = 4'd10;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       out_free;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || out_ready_i;

  // Sequencer for move and tick transactions.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.div_sel = DIV_WIDTH;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load_in = 1'b1;
          state_d = mode_i ? S_MULT : S_DELTA_GO;
        end
      end
      S_MULT: begin
        cmd_o.move_mul = 1'b1;
        state_d = S_PROD;
      end
      S_PROD: begin
        cmd_o.move_prod = 1'b1;
        state_d = S_RAMP_GO;
      end
      S_RAMP_GO: begin
        if (stat_i.ramp_zero) begin
          cmd_o.ramp_load = 1'b1;
          state_d = S_WIDTH_GO;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_RAMP;
          state_d = S_RAMP_WAIT;
        end
      end
      S_RAMP_WAIT: begin
        cmd_o.div_sel = DIV_RAMP;
        if (stat_i.div_done) begin
          cmd_o.ramp_load = 1'b1;
          state_d = S_WIDTH_GO;
        end
      end
      S_DELTA_GO: begin
        cmd_o.delta_load = 1'b1;
        state_d = S_SPEED;
      end
      S_SPEED: begin
        if (stat_i.speed_change) begin
          cmd_o.speed_upd = 1'b1;
          state_d = S_WIDTH_GO;
        end else begin
          state_d = S_DONE;
        end
      end
      S_WIDTH_GO: begin
        cmd_o.div_start = 1'b1;
        state_d = S_WIDTH_WAIT;
      end
      S_WIDTH_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.width_load = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Result valid: set on load, cleared when the transaction is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* src/stsp_checker.sv */
module stsp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [stsp_pkg::StepsW-1:0]  step_width_o,
  input logic [stsp_pkg::StepsW-1:0]  ramp_steps_o,
  input logic [stsp_pkg::StepsW-1:0]  steps_needed_o,
  input logic                         restart_o
);

  // A waiting result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A waiting result keeps its step width.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(step_width_o))
    else $error("step width changed while stalled");

  // Accepting a transaction leaves the idle state, so input is closed right after one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input reopened right after a transaction");

  // A move never reserves more than half its steps for the ramp.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && restart_o |-> ramp_steps_o <= (steps_needed_o >> 1))
    else $error("ramp longer than half the move");

endmodule

bind stepper_trapezoid_speed_profile stsp_checker u_stsp_checker (.*);

/* dv/stsp_checker.sv */
module stsp_scoreboard #(
  parameter int unsigned TICKS_PER_SECOND = 1000
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [stsp_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [stsp_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic                              mode_i,
  input  logic [stsp_pkg::StepsW-1:0]       remaining_steps_i,
  input  logic signed [stsp_pkg::DistW-1:0] distance_mm_i,
  input  logic [stsp_pkg::MultW-1:0]        speed_mult_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [stsp_pkg::StepsW-1:0]       step_width_i,
  input  logic [stsp_pkg::SpeedW-1:0]       speed_now_i,
  input  logic                              direction_i,
  input  logic [stsp_pkg::StepsW-1:0]       ramp_steps_i,
  input  logic [stsp_pkg::StepsW-1:0]       steps_needed_i,
  input  logic                              restart_i,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o,
  output int unsigned                       checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import stsp_pkg::*;

  localparam longint unsigned Max24 = 64'hFF_FFFF;
  localparam longint unsigned Max26 = 64'h3FF_FFFF;
  localparam longint unsigned Max28 = 64'hFFF_FFFF;

  typedef struct packed {
    logic [StepsW-1:0] step_width;
    logic [SpeedW-1:0] speed_now;
    logic              direction;
    logic [StepsW-1:0] ramp_steps;
    logic [StepsW-1:0] steps_needed;
    logic              restart;
  } profile_t;

  // Register copy.
  longint unsigned min_spd, clk_rate, max_spd, max_acc, spmm;
  // Profile state.
  longint unsigned cur_spd, tgt_spd, acc, ramp_cnt, fwd, steps_cnt, width;

  profile_t expected_q[$];
  int unsigned fails, checked;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();
  assign checked_o    = checked;

  function automatic longint unsigned clamp(longint unsigned v, longint unsigned m);
    return (v > m) ? m : v;
  endfunction

  function automatic longint unsigned width_for(longint unsigned s, longint unsigned c);
    if (s == 0) return Max24;
    return clamp((c << 8) / s, Max24);
  endfunction

  // Advances the speed profile by one transaction and queues its result.
  task automatic advance_profile(logic is_move, longint unsigned rem,
                                 logic signed [DistW-1:0] dist_in, longint unsigned mult);
    longint unsigned mag, dv, delta;
    profile_t r;
    if (is_move) begin
      tgt_spd = clamp((mult * max_spd) >> 8, Max26);
      acc     = clamp((mult * max_acc) >> 8, Max28);
      fwd     = (dist_in >= 0);
      mag     = (dist_in < 0) ? longint'(-longint'(dist_in)) : longint'(dist_in);
      steps_cnt = clamp((spmm * mag) >> 16, Max24);
      if (acc == 0 || tgt_spd <= min_spd) begin
        ramp_cnt = 0;
      end else begin
        dv = tgt_spd - min_spd;
        ramp_cnt = (dv * (min_spd + tgt_spd)) / (acc << 9);
      end
      if (ramp_cnt > (steps_cnt >> 1)) ramp_cnt = steps_cnt >> 1;
      cur_spd = min_spd;
      width   = width_for(cur_spd, clk_rate);
    end else begin
      delta = acc / TICKS_PER_SECOND;
      if (rem < ramp_cnt) begin
        // Slowing down toward the minimum.
        if (cur_spd > min_spd) begin
          cur_spd = (cur_spd - min_spd <= delta) ? min_spd : cur_spd - delta;
          width = width_for(cur_spd, clk_rate);
        end
      end else if (cur_spd < tgt_spd) begin
        // Speeding up toward the target.
        cur_spd = (tgt_spd - cur_spd <= delta) ? tgt_spd : cur_spd + delta;
        width = width_for(cur_spd, clk_rate);
      end
    end
    r.step_width   = width[StepsW-1:0];
    r.speed_now    = cur_spd[SpeedW-1:0];
    r.direction    = fwd[0];
    r.ramp_steps   = ramp_cnt[StepsW-1:0];
    r.steps_needed = steps_cnt[StepsW-1:0];
    r.restart      = is_move;
    expected_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    profile_t got, exp_r;
    if (!rst_ni) begin
      min_spd = MinSpeedRst; clk_rate = StepClockRst; max_spd = MaxSpeedRst;
      max_acc = MaxAccelRst; spmm = StepsPerMmRst;
      cur_spd = MinSpeedRst; tgt_spd = MinSpeedRst; acc = 0; ramp_cnt = 0;
      fwd = 1; steps_cnt = 0; width = width_for(cur_spd, clk_rate);
      expected_q.delete();
      fails = 0;
      checked = 0;
    end else begin
      // Register writes; indexes past the list are dropped.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_SPEED:    min_spd  = cfg_data_i & Max26;
          CFG_STEP_CLOCK:   clk_rate = cfg_data_i & Max24;
          CFG_MAX_SPEED:    max_spd  = cfg_data_i & Max26;
          CFG_MAX_ACCEL:    max_acc  = cfg_data_i & Max28;
          CFG_STEPS_PER_MM: spmm     = cfg_data_i & Max24;
          default: ;
        endcase
      end
      // Compare an accepted result with the oldest expectation.
      if (out_valid_i && out_ready_i) begin
        got = '{step_width_i, speed_now_i, direction_i, ramp_steps_i, steps_needed_i,
                restart_i};
        checked++;
        if (expected_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("%0t: result with nothing expected: %p", $realtime, got);
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            fails++;
            if (fails <= 10)
              $display("%0t: mismatch\n  expected %p\n  actual   %p", $realtime, exp_r, got);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        advance_profile(mode_i, remaining_steps_i, distance_mm_i, speed_mult_i);
    end
  end

endmodule

/* dv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import stsp_pkg::*;

  logic clk, rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  logic in_valid, in_ready, mode;
  logic [StepsW-1:0] remaining;
  logic signed [DistW-1:0] distance;
  logic [MultW-1:0] mult;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [StepsW-1:0] step_width, ramp_steps, steps_needed;
  logic [SpeedW-1:0] speed_now;
  logic direction, restart;
  int unsigned fail_count, pending, checked;
  int unsigned burst_left, moves_sent, ticks_sent, settings_used;

  stepper_trapezoid_speed_profile dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .in_valid_i(in_valid), .in_ready_o(in_ready),
    .mode_i(mode), .remaining_steps_i(remaining), .distance_mm_i(distance),
    .speed_mult_i(mult), .out_valid_o(out_valid), .out_ready_i(out_ready),
    .step_width_o(step_width), .speed_now_o(speed_now), .direction_o(direction),
    .ramp_steps_o(ramp_steps), .steps_needed_o(steps_needed), .restart_o(restart)
  );

  stsp_scoreboard chk (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .in_valid_i(in_valid), .in_ready_i(in_ready),
    .mode_i(mode), .remaining_steps_i(remaining), .distance_mm_i(distance),
    .speed_mult_i(mult), .out_valid_i(out_valid), .out_ready_i(out_ready),
    .step_width_i(step_width), .speed_now_i(speed_now), .direction_i(direction),
    .ramp_steps_i(ramp_steps), .steps_needed_i(steps_needed), .restart_i(restart),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stalls: long stretches of always-ready, random stalls or long holds.
  int unsigned stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    case ((stall_phase / 200) % 3)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Sends one transaction, with bursts of random length and gaps between them.
  task automatic send(logic m, logic [StepsW-1:0] r, logic signed [DistW-1:0] d,
                      logic [MultW-1:0] k);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    mode      <= m;
    remaining <= r;
    distance  <= d;
    mult      <= k;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    if (m) moves_sent++; else ticks_sent++;
  endtask

  // Lets the block drain before a register write.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    do @(negedge clk); while (pending != 0);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_setting(logic [CfgDataW-1:0] vmin, logic [CfgDataW-1:0] vclk,
                              logic [CfgDataW-1:0] vmax, logic [CfgDataW-1:0] vacc,
                              logic [CfgDataW-1:0] vspm);
    drain();
    write_reg(CFG_MIN_SPEED, vmin);
    write_reg(CFG_STEP_CLOCK, vclk);
    write_reg(CFG_MAX_SPEED, vmax);
    write_reg(CFG_MAX_ACCEL, vacc);
    write_reg(CFG_STEPS_PER_MM, vspm);
    settings_used++;
  endtask

  // A move followed by a countdown of ticks, so remaining steps can cross the ramp threshold.
  task automatic run_move();
    int unsigned n, rem, stepdown;
    logic signed [DistW-1:0] d;
    d = ($urandom_range(0, 3) == 0) ? DistW'($urandom)
                                    : DistW'($signed($urandom_range(0, 8000)) - 4000);
    send(1'b1, StepsW'($urandom), d, MultW'($urandom));
    n = $urandom_range(8, 40);
    rem = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 24'hFF_FFFF)
                                      : $urandom_range(0, 20000);
    stepdown = rem / n + 1;
    repeat (n) begin
      send(1'b0, StepsW'(rem), DistW'($urandom), MultW'($urandom));
      rem = (rem > stepdown) ? rem - $urandom_range(0, 2 * stepdown) % (rem + 1) : 0;
    end
  endtask

  task automatic random_phase(int unsigned items);
    int unsigned start;
    start = moves_sent + ticks_sent;
    while (moves_sent + ticks_sent - start < items) begin
      if ($urandom_range(0, 9) < 8) begin
        run_move();
      end else begin
        send(1'($urandom_range(0, 1)), StepsW'($urandom), DistW'($urandom),
             MultW'($urandom));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0; cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
    in_valid = 1'b0; mode = 1'b0; remaining = '0; distance = '0; mult = '0;
    burst_left = 0; moves_sent = 0; ticks_sent = 0; settings_used = 1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: ticks before any move, field extremes, zero and full multiplier.
    send(1'b0, '0, '0, '0);
    send(1'b0, '1, '0, '0);
    send(1'b1, '0, 24'sd0, 10'd256);
    send(1'b1, '0, 24'sh7F_FFFF, 10'd1023);
    send(1'b0, '1, '0, '0);
    send(1'b0, '1, '0, '0);
    send(1'b0, '0, '0, '0);
    send(1'b1, '1, 24'sh80_0000, 10'd1023);
    send(1'b1, '0, -24'sd1, 10'd512);
    send(1'b1, '0, 24'sd2560, 10'd0);
    send(1'b0, 24'd100, '0, '0);
    send(1'b1, '0, 24'sd512, 10'd1);
    send(1'b1, '0, 24'sd100000, 10'd768);
    send(1'b0, 24'd20000, '0, '0);
    send(1'b0, 24'd0, '0, '0);
    send(1'b0, 24'd0, '0, '0);

    // Out-of-range register index must be ignored.
    drain();
    cfg_we <= 1'b1; cfg_idx <= CfgIdxW'(5); cfg_data <= '1;
    @(posedge clk);
    cfg_we <= 1'b0;
    send(1'b1, '0, 24'sd5000, 10'd300);
    send(1'b0, 24'd9999, '0, '0);

    random_phase(250);

    // Pause with the sender until every result is back, then continue.
    drain();
    random_phase(50);

    // Low extremes, target at or below minimum and zero acceleration.
    load_setting(28'd256, 28'd1, 28'd256, 28'd0, 28'd0);
    random_phase(150);
    // High extremes.
    load_setting(28'h3FF_FFFF, 28'hFF_FFFF, 28'h3FF_FFFF, 28'hFFF_FFFF, 28'hFF_FFFF);
    random_phase(150);
    // Quick ramps with small minimum and strong acceleration.
    load_setting(28'd256, 28'hFF_FFFF, 28'd5000000, 28'hFFF_FFFF, 28'd25600);
    random_phase(250);
    // Random settings.
    repeat (2) begin
      load_setting($urandom_range(256, 28'h3FF_FFFF), $urandom_range(1, 28'hFF_FFFF),
                   $urandom_range(256, 28'h3FF_FFFF), $urandom_range(0, 28'hFFF_FFFF),
                   $urandom_range(0, 28'hFF_FFFF));
      random_phase(200);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    do @(negedge clk); while (pending != 0);
    repeat (150) @(posedge clk);

    $display("Covered %0d moves and %0d ticks under %0d register settings;",
             moves_sent, ticks_sent, settings_used);
    $display("%0d results compared, %0d mismatches.", checked, fail_count);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d results outstanding.", pending);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* files.f */
src/stsp_pkg.sv
src/stsp_div.sv
src/stsp_datapath.sv
src/stsp_ctrl.sv
src/stepper_trapezoid_speed_profile.sv
src/stsp_checker.sv
dv/stsp_checker.sv
dv/tb_top.sv
